>>> sv/breadcrumb_follow_guidance_assert.svh
// Assertion macros for the breadcrumb guidance sequencer (bfg_ctrl).
`ifndef BREADCRUMB_FOLLOW_GUIDANCE_ASSERT_SVH
`define BREADCRUMB_FOLLOW_GUIDANCE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define BFG_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define BFG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/bfg_pkg.sv
// ----------------------------------------------------------------------------
// bfg_pkg
// Types, constants and helpers shared by the breadcrumb guidance block.
// ----------------------------------------------------------------------------
package bfg_pkg;

    // Default depth of the waypoint store.
    localparam int unsigned MAX_CRUMBS_DEF = 256;

    // Largest distance value, Q16.16.
    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

    // Upper bound of the depth interpolation step.
    localparam logic [63:0] STEP_CAP = 64'h0000_0002_0000_0000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FAR     = 3'd0,
        CFG_NEAR    = 3'd1,
        CFG_SPACING = 3'd2,
        CFG_FAST    = 3'd3,
        CFG_SLOW    = 3'd4,
        CFG_IDLE    = 3'd5,
        CFG_DEPTH   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [30:0]        far_distance;
        logic [30:0]        near_distance;
        logic [30:0]        crumb_spacing;
        logic signed [15:0] fast_speed;
        logic signed [15:0] slow_speed;
        logic signed [15:0] idle_speed;
        logic               depth_mode;
    } cfg_t;

    typedef struct packed {
        logic               enable;
        logic               restart;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] own_x;
        logic signed [31:0] own_y;
        logic signed [31:0] own_z;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] speed_cmd;
        logic               line_follow_on;
        logic               depth_on;
        logic signed [31:0] depth_setpoint;
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] seg_end_x;
        logic signed [31:0] seg_end_y;
        logic [30:0]        target_range;
        logic [30:0]        crumb_gap;
        logic               list_full;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } arith_op_t;

    typedef struct packed {
        logic        start;
        arith_op_t   op;
        logic [63:0] a;
        logic [32:0] b;
    } arith_req_t;

    typedef struct packed {
        logic        done;
        logic [65:0] res;
    } arith_rsp_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT0,
        ST_INIT1,
        ST_DIST_X,
        ST_DIST_Y,
        ST_DIST_Z,
        ST_DIST_SQRT,
        ST_DIST_WAIT,
        ST_RD_LAST,
        ST_RD_LAST_W,
        ST_APPEND,
        ST_DECIDE,
        ST_DEPTH_MUL,
        ST_DEPTH_DIV,
        ST_DEPTH_WAIT,
        ST_PASS_M1,
        ST_PASS_M2,
        ST_PASS_EVAL,
        ST_ADV_RD0,
        ST_ADV_RD1,
        ST_ADV_LOAD,
        ST_OUT
    } ctrl_state_t;

    // Which distance the sequencer is working on.
    typedef enum logic [1:0] {
        DK_SEGLEN_INIT,
        DK_RANGE,
        DK_GAP,
        DK_SEGLEN_ADV
    } dist_kind_t;

    // Difference of two Q16.16 values without overflow.
    function automatic logic signed [32:0] diff33(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        diff33 = {a[31], a} - {b[31], b};
    endfunction

    // Magnitude of a 33-bit signed value; the most negative value maps to 2^32.
    function automatic logic [32:0] mag33(input logic signed [32:0] d);
        mag33 = d[32] ? 33'(-d) : 33'(d);
    endfunction

endpackage

>>> sv/bfg_crumb_mem.sv
// ----------------------------------------------------------------------------
// bfg_crumb_mem
// Waypoint store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bfg_crumb_mem #(
    parameter int unsigned DEPTH = bfg_pkg::MAX_CRUMBS_DEF,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  bfg_pkg::point_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output bfg_pkg::point_t rd_data
);

    bfg_pkg::point_t mem [DEPTH];
    bfg_pkg::point_t rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/bfg_arith.sv
// ----------------------------------------------------------------------------
// bfg_arith
// Shared arithmetic unit: a 33x33 multiply, a bit-serial integer square root
// and a restoring divide that share one 64-bit subtractor.
// ----------------------------------------------------------------------------
module bfg_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  bfg_pkg::arith_req_t req,
    output bfg_pkg::arith_rsp_t rsp
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    bfg_pkg::arith_op_t  op_reg, op_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [63:0]         acc_reg, acc_next;
    logic [63:0]         root_reg, root_next;
    logic [63:0]         bit_reg, bit_next;
    logic [30:0]         rem_reg, rem_next;
    logic [30:0]         divisor_reg, divisor_next;
    logic [65:0]         res_reg, res_next;

    logic [63:0] sub_a;
    logic [63:0] sub_b;
    logic [64:0] diff;
    logic        ge;
    logic [63:0] step_root;

    // Shared subtractor operands.
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        case (op_reg)
            bfg_pkg::OP_SQRT:
            begin
                sub_a = acc_reg;
                sub_b = root_reg + bit_reg;
            end
            bfg_pkg::OP_DIV:
            begin
                sub_a = {32'b0, rem_reg, acc_reg[63]};
                sub_b = {33'b0, divisor_reg};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = ~diff[64];

    // Next values of the iteration registers.
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        res_next     = res_reg;
        step_root    = root_reg;
        if (req.start)
        begin
            op_next = req.op;
            case (req.op)
                bfg_pkg::OP_MUL:
                begin
                    res_next = 66'(req.a[32:0]) * 66'(req.b);
                end
                bfg_pkg::OP_SQRT:
                begin
                    busy_next = 1'b1;
                    acc_next  = req.a;
                    root_next = '0;
                    bit_next  = 64'h4000_0000_0000_0000;
                    cnt_next  = 6'd31;
                end
                bfg_pkg::OP_DIV:
                begin
                    busy_next    = 1'b1;
                    acc_next     = req.a;
                    root_next    = '0;
                    rem_next     = '0;
                    divisor_next = req.b[30:0];
                    cnt_next     = 6'd63;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (op_reg == bfg_pkg::OP_SQRT)
            begin
                if (ge)
                begin
                    acc_next  = diff[63:0];
                    step_root = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    step_root = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                rem_next  = ge ? diff[30:0] : sub_a[30:0];
                acc_next  = {acc_reg[62:0], 1'b0};
                step_root = {root_reg[62:0], ge};
            end
            root_next = step_root;
            cnt_next  = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = {2'b0, step_root};
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= bfg_pkg::OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        res_reg     <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

>>> sv/bfg_ctrl.sv
// ----------------------------------------------------------------------------
// bfg_ctrl
// Tick sequencer: waypoint list upkeep, distances, speed choice, depth
// interpolation and segment advance; its arithmetic goes through the shared unit.
// ----------------------------------------------------------------------------
`include "breadcrumb_follow_guidance_assert.svh"

module bfg_ctrl #(
    parameter int unsigned MAX_CRUMBS = bfg_pkg::MAX_CRUMBS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bfg_pkg::in_item_t   in_data,
    input  bfg_pkg::cfg_t       cfg,
    input  logic                res_free,
    output logic                res_load,
    output bfg_pkg::out_item_t  res_data,
    output bfg_pkg::arith_req_t areq,
    input  bfg_pkg::arith_rsp_t arsp
);

    localparam int unsigned AW = $clog2(MAX_CRUMBS);
    localparam int unsigned CW = $clog2(MAX_CRUMBS + 1);
    localparam int unsigned XW = AW + 2;

    bfg_pkg::ctrl_state_t state_reg, state_next;
    bfg_pkg::dist_kind_t  kind_reg, kind_next;
    bfg_pkg::in_item_t    item_reg, item_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        seg_index_reg, seg_index_next;
    bfg_pkg::point_t      seg_start_reg, seg_start_next;
    bfg_pkg::point_t      seg_end_reg, seg_end_next;
    logic [30:0]          seg_length_reg, seg_length_next;
    logic signed [31:0]   depth_hold_reg, depth_hold_next;
    bfg_pkg::point_t      pa_reg, pa_next;
    bfg_pkg::point_t      pb_reg, pb_next;
    logic [63:0]          acc_reg, acc_next;
    logic [30:0]          range_reg, range_next;
    logic [30:0]          gap_reg, gap_next;
    logic signed [15:0]   speed_reg, speed_next;
    logic                 lf_reg, lf_next;
    logic                 don_reg, don_next;
    logic [65:0]          m1_reg, m1_next;

    logic            accept;
    bfg_pkg::point_t tgt_pt, own_pt, second_pt, in_tgt_pt, in_own_pt;
    logic [32:0]     mx, my, mz;
    logic            dist_sat;
    logic            dist_fin;
    logic [30:0]     dist_val;

    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    bfg_pkg::point_t      mem_wr_data;
    logic [AW-1:0]        mem_rd_addr;
    bfg_pkg::point_t      mem_rd_data;

    logic signed [32:0] d1, e1, d2, e2;
    logic               n1, n2, passed;
    logic               can_advance;
    logic               can_append;

    logic signed [32:0] dz;
    logic [33:0]        step;
    logic signed [35:0] zb36, za36, z36, lo36, hi36, zc36;

    // Points of the item.
    always_comb
    begin
        tgt_pt    = '{x: item_reg.target_x, y: item_reg.target_y, z: item_reg.target_z};
        own_pt    = '{x: item_reg.own_x, y: item_reg.own_y, z: item_reg.own_z};
        in_tgt_pt = '{x: in_data.target_x, y: in_data.target_y, z: in_data.target_z};
        in_own_pt = '{x: in_data.own_x, y: in_data.own_y, z: in_data.own_z};
        second_pt = (item_reg.target_x != 32'sd0 && item_reg.target_y != 32'sd0)
                    ? tgt_pt : own_pt;
    end

    assign accept = in_valid && (state_reg == bfg_pkg::ST_IDLE);

    // Axis magnitudes of the distance in progress.
    always_comb
    begin
        mx = bfg_pkg::mag33(bfg_pkg::diff33(pa_reg.x, pb_reg.x));
        my = bfg_pkg::mag33(bfg_pkg::diff33(pa_reg.y, pb_reg.y));
        mz = cfg.depth_mode ? bfg_pkg::mag33(bfg_pkg::diff33(pa_reg.z, pb_reg.z)) : '0;
        dist_sat = (|mx[32:31]) || (|my[32:31]) || (|mz[32:31]);
    end

    // A distance finishes early on saturation or when the root is done.
    always_comb
    begin
        dist_fin = 1'b0;
        dist_val = bfg_pkg::SAT31;
        if (state_reg == bfg_pkg::ST_DIST_X && dist_sat)
        begin
            dist_fin = 1'b1;
        end
        else if (state_reg == bfg_pkg::ST_DIST_WAIT && arsp.done)
        begin
            dist_fin = 1'b1;
            dist_val = (|arsp.res[65:31]) ? bfg_pkg::SAT31 : arsp.res[30:0];
        end
    end

    // End-passed test on the current segment.
    always_comb
    begin
        d1 = bfg_pkg::diff33(seg_end_reg.x, seg_start_reg.x);
        e1 = bfg_pkg::diff33(item_reg.own_x, seg_end_reg.x);
        d2 = bfg_pkg::diff33(seg_end_reg.y, seg_start_reg.y);
        e2 = bfg_pkg::diff33(item_reg.own_y, seg_end_reg.y);
        n1 = (m1_reg != '0) && (d1[32] != e1[32]);
        n2 = (arsp.res != '0) && (d2[32] != e2[32]);
        if (!n1 && !n2)
        begin
            passed = 1'b1;
        end
        else if (n1 && n2)
        begin
            passed = 1'b0;
        end
        else if (n1)
        begin
            passed = arsp.res >= m1_reg;
        end
        else
        begin
            passed = m1_reg >= arsp.res;
        end
        can_advance = (XW'(seg_index_reg) + XW'(2)) < XW'(count_reg);
        can_append  = (gap_reg > cfg.crumb_spacing) && (count_reg < CW'(MAX_CRUMBS));
    end

    // Depth interpolation from the quotient, clamped between the endpoints.
    always_comb
    begin
        dz   = bfg_pkg::diff33(seg_end_reg.z, seg_start_reg.z);
        step = (arsp.res[63:0] > bfg_pkg::STEP_CAP) ? bfg_pkg::STEP_CAP[33:0]
                                                     : arsp.res[33:0];
        zb36 = 36'(seg_end_reg.z);
        za36 = 36'(seg_start_reg.z);
        z36  = dz[32] ? (zb36 + $signed({2'b0, step})) : (zb36 - $signed({2'b0, step}));
        lo36 = (za36 < zb36) ? za36 : zb36;
        hi36 = (za36 < zb36) ? zb36 : za36;
        if (z36 < lo36)
        begin
            zc36 = lo36;
        end
        else if (z36 > hi36)
        begin
            zc36 = hi36;
        end
        else
        begin
            zc36 = z36;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfg_pkg::ST_IDLE:
            begin
                if (accept && in_data.enable)
                begin
                    state_next = (in_data.restart || count_reg == '0)
                                 ? bfg_pkg::ST_INIT0 : bfg_pkg::ST_DIST_X;
                end
            end
            bfg_pkg::ST_INIT0:      state_next = bfg_pkg::ST_INIT1;
            bfg_pkg::ST_INIT1:      state_next = bfg_pkg::ST_DIST_X;
            bfg_pkg::ST_DIST_X,
            bfg_pkg::ST_DIST_WAIT:
            begin
                if (dist_fin)
                begin
                    unique case (kind_reg)
                        bfg_pkg::DK_SEGLEN_INIT: state_next = bfg_pkg::ST_DIST_X;
                        bfg_pkg::DK_RANGE:       state_next = bfg_pkg::ST_RD_LAST;
                        bfg_pkg::DK_GAP:         state_next = bfg_pkg::ST_APPEND;
                        default:                 state_next = bfg_pkg::ST_OUT;
                    endcase
                end
                else if (state_reg == bfg_pkg::ST_DIST_X)
                begin
                    state_next = bfg_pkg::ST_DIST_Y;
                end
            end
            bfg_pkg::ST_DIST_Y:     state_next = bfg_pkg::ST_DIST_Z;
            bfg_pkg::ST_DIST_Z:     state_next = bfg_pkg::ST_DIST_SQRT;
            bfg_pkg::ST_DIST_SQRT:  state_next = bfg_pkg::ST_DIST_WAIT;
            bfg_pkg::ST_RD_LAST:    state_next = bfg_pkg::ST_RD_LAST_W;
            bfg_pkg::ST_RD_LAST_W:  state_next = bfg_pkg::ST_DIST_X;
            bfg_pkg::ST_APPEND:     state_next = bfg_pkg::ST_DECIDE;
            bfg_pkg::ST_DECIDE:
            begin
                if (range_reg <= cfg.near_distance)
                begin
                    state_next = bfg_pkg::ST_OUT;
                end
                else if (cfg.depth_mode && seg_length_reg != '0)
                begin
                    state_next = bfg_pkg::ST_DEPTH_MUL;
                end
                else
                begin
                    state_next = bfg_pkg::ST_PASS_M1;
                end
            end
            bfg_pkg::ST_DEPTH_MUL:  state_next = bfg_pkg::ST_DEPTH_DIV;
            bfg_pkg::ST_DEPTH_DIV:  state_next = bfg_pkg::ST_DEPTH_WAIT;
            bfg_pkg::ST_DEPTH_WAIT:
            begin
                if (arsp.done)
                begin
                    state_next = bfg_pkg::ST_PASS_M1;
                end
            end
            bfg_pkg::ST_PASS_M1:    state_next = bfg_pkg::ST_PASS_M2;
            bfg_pkg::ST_PASS_M2:    state_next = bfg_pkg::ST_PASS_EVAL;
            bfg_pkg::ST_PASS_EVAL:
            begin
                state_next = (passed && can_advance) ? bfg_pkg::ST_ADV_RD0 : bfg_pkg::ST_OUT;
            end
            bfg_pkg::ST_ADV_RD0:    state_next = bfg_pkg::ST_ADV_RD1;
            bfg_pkg::ST_ADV_RD1:    state_next = bfg_pkg::ST_ADV_LOAD;
            bfg_pkg::ST_ADV_LOAD:   state_next = bfg_pkg::ST_DIST_X;
            bfg_pkg::ST_OUT:
            begin
                if (res_free)
                begin
                    state_next = bfg_pkg::ST_IDLE;
                end
            end
            default:                state_next = bfg_pkg::ST_IDLE;
        endcase
    end

    // Outputs: handshake, memory ports and arithmetic requests.
    always_comb
    begin
        in_stall    = (state_reg != bfg_pkg::ST_IDLE);
        res_load    = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = own_pt;
        mem_rd_addr = seg_index_reg;
        areq.start  = 1'b0;
        areq.op     = bfg_pkg::OP_MUL;
        areq.a      = '0;
        areq.b      = '0;
        unique case (state_reg)
            bfg_pkg::ST_INIT0:
            begin
                mem_wr_en = 1'b1;
            end
            bfg_pkg::ST_INIT1:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(1);
                mem_wr_data = second_pt;
            end
            bfg_pkg::ST_DIST_X:
            begin
                areq.start = !dist_sat;
                areq.a     = {31'b0, mx};
                areq.b     = mx;
            end
            bfg_pkg::ST_DIST_Y:
            begin
                areq.start = 1'b1;
                areq.a     = {31'b0, my};
                areq.b     = my;
            end
            bfg_pkg::ST_DIST_Z:
            begin
                areq.start = 1'b1;
                areq.a     = {31'b0, mz};
                areq.b     = mz;
            end
            bfg_pkg::ST_DIST_SQRT:
            begin
                areq.start = 1'b1;
                areq.op    = bfg_pkg::OP_SQRT;
                areq.a     = acc_reg + arsp.res[63:0];
            end
            bfg_pkg::ST_RD_LAST:
            begin
                mem_rd_addr = AW'(count_reg - CW'(1));
            end
            bfg_pkg::ST_APPEND:
            begin
                mem_wr_en   = can_append;
                mem_wr_addr = count_reg[AW-1:0];
                mem_wr_data = tgt_pt;
            end
            bfg_pkg::ST_DEPTH_MUL:
            begin
                areq.start = 1'b1;
                areq.a     = {33'b0, range_reg};
                areq.b     = bfg_pkg::mag33(dz);
            end
            bfg_pkg::ST_DEPTH_DIV:
            begin
                areq.start = 1'b1;
                areq.op    = bfg_pkg::OP_DIV;
                areq.a     = arsp.res[63:0];
                areq.b     = {2'b0, seg_length_reg};
            end
            bfg_pkg::ST_PASS_M1:
            begin
                areq.start = 1'b1;
                areq.a     = {31'b0, bfg_pkg::mag33(d1)};
                areq.b     = bfg_pkg::mag33(e1);
            end
            bfg_pkg::ST_PASS_M2:
            begin
                areq.start = 1'b1;
                areq.a     = {31'b0, bfg_pkg::mag33(d2)};
                areq.b     = bfg_pkg::mag33(e2);
            end
            bfg_pkg::ST_ADV_RD1:
            begin
                mem_rd_addr = seg_index_reg + AW'(1);
            end
            bfg_pkg::ST_OUT:
            begin
                res_load = res_free;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    // Next values of the tick datapath.
    always_comb
    begin
        kind_next       = kind_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        seg_index_next  = seg_index_reg;
        seg_start_next  = seg_start_reg;
        seg_end_next    = seg_end_reg;
        seg_length_next = seg_length_reg;
        depth_hold_next = depth_hold_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        acc_next        = acc_reg;
        range_next      = range_reg;
        gap_next        = gap_reg;
        speed_next      = speed_reg;
        lf_next         = lf_reg;
        don_next        = don_reg;
        m1_next         = m1_reg;
        case (state_reg)
            bfg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    item_next = in_data;
                    pa_next   = in_tgt_pt;
                    pb_next   = in_own_pt;
                    kind_next = bfg_pkg::DK_RANGE;
                end
            end
            bfg_pkg::ST_INIT1:
            begin
                count_next     = CW'(2);
                seg_index_next = '0;
                seg_start_next = own_pt;
                seg_end_next   = second_pt;
                pa_next        = own_pt;
                pb_next        = second_pt;
                kind_next      = bfg_pkg::DK_SEGLEN_INIT;
            end
            bfg_pkg::ST_DIST_X,
            bfg_pkg::ST_DIST_WAIT:
            begin
                if (dist_fin)
                begin
                    case (kind_reg)
                        bfg_pkg::DK_SEGLEN_INIT:
                        begin
                            seg_length_next = dist_val;
                            pa_next         = tgt_pt;
                            pb_next         = own_pt;
                            kind_next       = bfg_pkg::DK_RANGE;
                        end
                        bfg_pkg::DK_RANGE:  range_next = dist_val;
                        bfg_pkg::DK_GAP:    gap_next = dist_val;
                        default:            seg_length_next = dist_val;
                    endcase
                end
            end
            bfg_pkg::ST_DIST_Y:     acc_next = arsp.res[63:0];
            bfg_pkg::ST_DIST_Z:     acc_next = acc_reg + arsp.res[63:0];
            bfg_pkg::ST_RD_LAST_W:
            begin
                pa_next   = tgt_pt;
                pb_next   = mem_rd_data;
                kind_next = bfg_pkg::DK_GAP;
            end
            bfg_pkg::ST_APPEND:
            begin
                if (can_append)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            bfg_pkg::ST_DECIDE:
            begin
                don_next   = 1'b0;
                lf_next    = 1'b0;
                speed_next = cfg.idle_speed;
                if (range_reg > cfg.near_distance)
                begin
                    lf_next    = 1'b1;
                    speed_next = (range_reg > cfg.far_distance) ? cfg.fast_speed
                                                                : cfg.slow_speed;
                    if (cfg.depth_mode && seg_length_reg == '0)
                    begin
                        depth_hold_next = seg_end_reg.z;
                        don_next        = 1'b1;
                    end
                end
            end
            bfg_pkg::ST_DEPTH_WAIT:
            begin
                if (arsp.done)
                begin
                    depth_hold_next = zc36[31:0];
                    don_next        = 1'b1;
                end
            end
            bfg_pkg::ST_PASS_M2:    m1_next = arsp.res;
            bfg_pkg::ST_PASS_EVAL:
            begin
                if (passed)
                begin
                    if (can_advance)
                    begin
                        seg_index_next = seg_index_reg + AW'(1);
                    end
                    else
                    begin
                        lf_next    = 1'b0;
                        speed_next = cfg.idle_speed;
                    end
                end
            end
            bfg_pkg::ST_ADV_RD1:    seg_start_next = mem_rd_data;
            bfg_pkg::ST_ADV_LOAD:
            begin
                seg_end_next = mem_rd_data;
                pa_next      = seg_start_reg;
                pb_next      = mem_rd_data;
                kind_next    = bfg_pkg::DK_SEGLEN_ADV;
            end
            default:
            begin
                kind_next = kind_reg;
            end
        endcase
    end

    // State that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfg_pkg::ST_IDLE;
            count_reg      <= '0;
            seg_index_reg  <= '0;
            seg_start_reg  <= '0;
            seg_end_reg    <= '0;
            seg_length_reg <= '0;
            depth_hold_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            seg_index_reg  <= seg_index_next;
            seg_start_reg  <= seg_start_next;
            seg_end_reg    <= seg_end_next;
            seg_length_reg <= seg_length_next;
            depth_hold_reg <= depth_hold_next;
        end
    end

    // Working registers of the tick.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        item_reg  <= item_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        acc_reg   <= acc_next;
        range_reg <= range_next;
        gap_reg   <= gap_next;
        speed_reg <= speed_next;
        lf_reg    <= lf_next;
        don_reg   <= don_next;
        m1_reg    <= m1_next;
    end

    // Waypoint store.
    bfg_crumb_mem #(
        .DEPTH (MAX_CRUMBS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Result of the tick.
    always_comb
    begin
        res_data.speed_cmd      = speed_reg;
        res_data.line_follow_on = lf_reg;
        res_data.depth_on       = don_reg;
        res_data.depth_setpoint = depth_hold_reg;
        res_data.seg_start_x    = seg_start_reg.x;
        res_data.seg_start_y    = seg_start_reg.y;
        res_data.seg_end_x      = seg_end_reg.x;
        res_data.seg_end_y      = seg_end_reg.y;
        res_data.target_range   = range_reg;
        res_data.crumb_gap      = gap_reg;
        res_data.list_full      = (count_reg == CW'(MAX_CRUMBS));
    end

    // The waypoint count never runs past the store.
    `BFG_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_CRUMBS), "crumb count overflow")

    // Between ticks a loaded segment always lies inside the list.
    `BFG_ASSERT_IMPLY(a_seg_inside, clk, rst_n, (state_reg == bfg_pkg::ST_IDLE) && (count_reg != '0), (count_reg >= CW'(2)) && ((XW'(seg_index_reg) + XW'(1)) < XW'(count_reg)), "segment outside waypoint list")

    // Iterative results only arrive while the sequencer waits for them.
    `BFG_ASSERT_IMPLY(a_done_waited, clk, rst_n, arsp.done, (state_reg == bfg_pkg::ST_DIST_WAIT) || (state_reg == bfg_pkg::ST_DEPTH_WAIT), "arithmetic result not awaited")

endmodule

>>> sv/breadcrumb_follow_guidance.sv
// ----------------------------------------------------------------------------
// breadcrumb_follow_guidance
// Breadcrumb trail follower: keeps a list of target waypoints, follows the
// segments between them and chooses speed, line following and depth.
// ----------------------------------------------------------------------------
// Usage:
//   One transfer on the input channel (in_valid, in_stall, in_data) is one
//   guidance tick. A tick with enable low is taken and gives no result; an
//   enabled tick gives exactly one transfer on the output channel
//   (out_valid, out_stall, out_data).
//   in_stall stays high while a tick is in work, so one tick is handled at a
//   time. Each distance of an enabled tick runs through the 32-step square
//   root of the shared arithmetic unit, and a depth setpoint adds a 64-step
//   divide through the same unit. Loading the first segment and advancing
//   to the next segment each add a distance for the segment length. A
//   distance whose axis difference saturates skips the multiplies and the
//   square root, which shortens the tick.
//   The result sits in an output register; the next tick is taken while it
//   waits, and out_stall only holds the sequencer once that tick is done.
//   Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
//   always ready; the user must make them while no tick is in work; the block
//   does not enforce this. Reset empties the waypoint list, clears the segment
//   and the held depth, and sets all configuration registers to zero.
// ----------------------------------------------------------------------------
module breadcrumb_follow_guidance #(
    parameter int unsigned MAX_CRUMBS = bfg_pkg::MAX_CRUMBS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bfg_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bfg_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    bfg_pkg::cfg_t       cfg_reg, cfg_next;
    logic                out_valid_reg, out_valid_next;
    bfg_pkg::out_item_t  out_data_reg;
    logic                res_free;
    logic                res_load;
    bfg_pkg::out_item_t  res_data;
    bfg_pkg::arith_req_t areq;
    bfg_pkg::arith_rsp_t arsp;

    assign cfg_ready = 1'b1;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (bfg_pkg::cfg_idx_t'(cfg_index))
                bfg_pkg::CFG_FAR:     cfg_next.far_distance  = cfg_data[30:0];
                bfg_pkg::CFG_NEAR:    cfg_next.near_distance = cfg_data[30:0];
                bfg_pkg::CFG_SPACING: cfg_next.crumb_spacing = cfg_data[30:0];
                bfg_pkg::CFG_FAST:    cfg_next.fast_speed    = cfg_data[15:0];
                bfg_pkg::CFG_SLOW:    cfg_next.slow_speed    = cfg_data[15:0];
                bfg_pkg::CFG_IDLE:    cfg_next.idle_speed    = cfg_data[15:0];
                bfg_pkg::CFG_DEPTH:   cfg_next.depth_mode    = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Output register: free when empty or when its transfer completes.
    assign res_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Tick sequencer with the waypoint store.
    bfg_ctrl #(
        .MAX_CRUMBS (MAX_CRUMBS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .res_free (res_free),
        .res_load (res_load),
        .res_data (res_data),
        .areq     (areq),
        .arsp     (arsp)
    );

    // Shared multiply, square root and divide unit.
    bfg_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .rsp   (arsp)
    );

endmodule
